@@ rtl/abcrf_pkg.sv @@
// shared types, constants and register indexes for the clipped alpha-blend fill
package abcrf_pkg;

	localparam int COORD_BITS = 16;
	// coordinates keep at most the 16 bits of their slot
	localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_FILL_COLOR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_AREA_RECT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_RECT = 2'd2;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [31:0] background;
	} in_t;

	typedef struct packed {
		logic [23:0] pixel_out;
		logic written;
	} out_t;

	// live configuration as the datapath sees it
	typedef struct packed {
		logic [7:0] alpha;
		logic [23:0] color;
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} cfg_t;

	// what the clip stage hands to the blend pipeline
	typedef struct packed {
		logic hit;
		logic [23:0] bg;
	} clip_t;

endpackage

@@ rtl/alpha_blend_clipped_rect_fill.sv @@
// top level of the clipped alpha-blend rectangle fill
//
// Takes one background pixel with its coordinate per clock and returns one result per
// pixel, in order. A pixel inside the fill rectangle clipped to the bound rectangle
// (inclusive edges) gets the fill colour blended over it and written set; any other
// pixel passes through with written clear. Throughput is one transaction per clock while
// the output is taken; there are four register stages: clip test, channel multiply,
// divide by 255 and the output register. The pipeline only holds when the output is
// not taken. Configuration registers reset to zero; rectangle writes take effect for the
// next pixel accepted after the write, and colour writes also reach a pixel in the clip stage.
module alpha_blend_clipped_rect_fill
	import abcrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data
);

	cfg_t cfg;
	logic clip_valid;
	logic clip_ready;
	clip_t clip_data;

	abcrf_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg (cfg)
	);

	abcrf_clip u_clip (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data (in_data),
		.out_valid (clip_valid),
		.out_ready (clip_ready),
		.out_data (clip_data)
	);

	abcrf_mix u_mix (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.in_valid (clip_valid),
		.in_ready (clip_ready),
		.in_data (clip_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data (out_data)
	);

`ifndef ASSERT_OFF
	// the input only stalls when the whole pipe is full behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && clip_valid))
		else $error("input stalled while pipeline can advance");
`endif

endmodule

@@ rtl/abcrf_cfg.sv @@
// configuration registers and the clipped rectangle derived from them
module abcrf_cfg
	import abcrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output cfg_t cfg
);

	logic [31:0] fill_color_q;
	logic [63:0] area_rect_q;
	logic [63:0] bound_rect_q;
	coord_t a_part [4];
	coord_t b_part [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
			area_rect_q <= '0;
			bound_rect_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILL_COLOR: fill_color_q <= cfg_wdata[31:0];
				REG_AREA_RECT: area_rect_q <= cfg_wdata;
				REG_BOUND_RECT: bound_rect_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// each edge is the low CW bits of its 16-bit slot, read as signed
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			a_part[k] = coord_t'(area_rect_q[16*k +: CW]);
			b_part[k] = coord_t'(bound_rect_q[16*k +: CW]);
		end
	end

	always_comb begin
		cfg.alpha = fill_color_q[31:24];
		cfg.color = fill_color_q[23:0];
		cfg.left = (a_part[0] > b_part[0]) ? a_part[0] : b_part[0];
		cfg.top = (a_part[1] > b_part[1]) ? a_part[1] : b_part[1];
		cfg.right = (a_part[2] < b_part[2]) ? a_part[2] : b_part[2];
		cfg.bottom = (a_part[3] < b_part[3]) ? a_part[3] : b_part[3];
	end

endmodule

@@ rtl/abcrf_clip.sv @@
// first pipeline stage: inside test against the clipped rectangle
module abcrf_clip
	import abcrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output clip_t out_data
);

	logic vld_s1;
	clip_t data_s1;
	coord_t x;
	coord_t y;
	logic hit;

	assign x = coord_t'(in_data.pixel_x[CW-1:0]);
	assign y = coord_t'(in_data.pixel_y[CW-1:0]);
	// an empty region fails one of these pairs for every coordinate
	assign hit = (x >= cfg.left) && (x <= cfg.right) &&
		(y >= cfg.top) && (y <= cfg.bottom);

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.hit <= hit;
			data_s1.bg <= in_data.background[23:0];
		end
	end

	assign out_valid = vld_s1;
	assign out_data = data_s1;

endmodule

@@ rtl/abcrf_mix.sv @@
// blend pipeline: channel products, divide by 255, sum and output select
module abcrf_mix
	import abcrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input clip_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data
);

	// floor(p / 255) for p up to 255 * 255, by reciprocal with correction
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] s;
		s = {1'b0, p} + 17'd1 + {9'b0, p[15:8]};
		return s[15:8];
	endfunction

	logic [7:0] weight;
	logic rdy_s2, rdy_s3, rdy_s4;
	logic vld_s2, vld_s3, vld_s4;
	clip_t data_s2, data_s3;
	logic [15:0] pf_s2 [3];
	logic [15:0] pb_s2 [3];
	logic [7:0] qf_s3 [3];
	logic [7:0] qb_s3 [3];
	logic [8:0] sum [3];
	out_t data_s4;

	// top byte is transparency, the fill weight is its complement
	assign weight = 8'd255 - cfg.alpha;

	assign rdy_s4 = !vld_s4 || out_ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= in_valid;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			data_s2 <= in_data;
			for (int c = 0; c < 3; c++) begin
				pf_s2[c] <= cfg.color[8*c +: 8] * weight;
				pb_s2[c] <= in_data.bg[8*c +: 8] * cfg.alpha;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			data_s3 <= data_s2;
			for (int c = 0; c < 3; c++) begin
				qf_s3[c] <= div255(pf_s2[c]);
				qb_s3[c] <= div255(pb_s2[c]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = {1'b0, qf_s3[c]} + {1'b0, qb_s3[c]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			data_s4.written <= data_s3.hit;
			if (data_s3.hit) begin
				data_s4.pixel_out <= {sum[2][7:0], sum[1][7:0], sum[0][7:0]};
			end else begin
				data_s4.pixel_out <= data_s3.bg;
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_data = data_s4;

`ifndef ASSERT_OFF
	// the two weighted parts of a channel never carry past eight bits
	a_sum_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (sum[0] <= 9'd255) && (sum[1] <= 9'd255) && (sum[2] <= 9'd255))
		else $error("blend channel sum exceeds 255");

	// a full pipe held by the output keeps every transaction in place
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && vld_s3 && vld_s4 && !out_ready) |=> (vld_s2 && vld_s3 && vld_s4))
		else $error("transaction lost in stalled blend pipeline");
`endif

endmodule

@@ bench/alpha_blend_clipped_rect_fill_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the clipped alpha-blend rectangle fill
module alpha_blend_clipped_rect_fill_tb;
	import abcrf_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam int PIPE_DEPTH = 4;

	// rectangles packed as {bottom, right, top, left}
	localparam logic [63:0] RECT_FULL = 64'h7FFF_7FFF_8000_8000;
	localparam logic [63:0] RECT_SCREEN = 64'h01DF_027F_0000_0000;
	localparam logic [63:0] RECT_BOX = 64'h003C_00C8_0032_0064;
	localparam logic [63:0] RECT_EMPTY = 64'h7FFF_0005_8000_000A;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0] wdata;
		in_t pix;
		logic known;
		out_t want;
	} step_row_t;

	typedef struct packed {
		logic known;
		out_t want;
	} typed_t;

	localparam int DIRECTED_ROWS = 31;

	step_row_t directed_rows [DIRECTED_ROWS] = '{
		// after reset the region is the single point at the origin, opaque black
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd0, 16'sd0, 32'hFFFF_FFFF}, 1'b1, '{24'h000000, 1'b1}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd1, 16'sd0, 32'h1234_5678}, 1'b1, '{24'h345678, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd0, -16'sd1, 32'h00AB_CDEF}, 1'b1, '{24'hABCDEF, 1'b0}},
		// upper half of the write data is not part of the colour
		'{ROW_WRITE, REG_FILL_COLOR, 64'hFFFF_FFFF_00A1_B2C3, '0, 1'b0, '0},
		'{ROW_WRITE, REG_AREA_RECT, RECT_FULL, '0, 1'b0, '0},
		'{ROW_WRITE, REG_BOUND_RECT, RECT_SCREEN, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd0, 16'sd0, 32'h0}, 1'b1, '{24'hA1B2C3, 1'b1}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd639, 16'sd479, 32'hFF_FFFFFF}, 1'b1, '{24'hA1B2C3, 1'b1}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd640, 16'sd479, 32'h00FE_DCBA}, 1'b1, '{24'hFEDCBA, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd639, 16'sd480, 32'h0001_0203}, 1'b1, '{24'h010203, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{-16'sd1, 16'sd0, 32'h8070_6050}, 1'b1, '{24'h706050, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{-16'sd32768, -16'sd32768, 32'hFFFF_FFFF},
			1'b1, '{24'hFFFFFF, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd32767, 16'sd32767, 32'h0}, 1'b1, '{24'h000000, 1'b0}},
		// fully transparent colour still flags the pixel
		'{ROW_WRITE, REG_FILL_COLOR, 64'hFF12_3456, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd320, 16'sd240, 32'hAB65_4321}, 1'b1, '{24'h654321, 1'b1}},
		'{ROW_WRITE, REG_FILL_COLOR, 64'h80FF_00FF, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd10, 16'sd10, 32'h0}, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd11, 16'sd10, 32'hFFFF_FFFF}, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd12, 16'sd10, 32'h005A_5A5A}, 1'b0, '0},
		// clipping by the fill rectangle instead of the bound
		'{ROW_WRITE, REG_BOUND_RECT, RECT_FULL, '0, 1'b0, '0},
		'{ROW_WRITE, REG_AREA_RECT, RECT_BOX, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd100, 16'sd50, 32'h0012_3456}, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd200, 16'sd60, 32'h00FE_0180}, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd99, 16'sd55, 32'h00C0_FFEE}, 1'b1, '{24'hC0FFEE, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd150, 16'sd61, 32'h0000_0001}, 1'b1, '{24'h000001, 1'b0}},
		// a spare register index must leave everything alone
		'{ROW_WRITE, REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd201, 16'sd50, 32'h0011_2233}, 1'b1, '{24'h112233, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd150, 16'sd55, 32'h7F7F_7F7F}, 1'b0, '0},
		// left beyond right leaves nothing to fill
		'{ROW_WRITE, REG_AREA_RECT, RECT_EMPTY, '0, 1'b0, '0},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd7, 16'sd0, 32'h0044_5566}, 1'b1, '{24'h445566, 1'b0}},
		'{ROW_PIXEL, REG_FILL_COLOR, 64'h0, '{16'sd5, 16'sd0, 32'h0099_8877}, 1'b1, '{24'h998877, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	logic [31:0] fill_model = '0;
	logic [63:0] area_model = '0;
	logic [63:0] bound_model = '0;

	out_t pending_pixels[$];
	typed_t typed_want[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	alpha_blend_clipped_rect_fill i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	function automatic int coord_of(logic [15:0] v);
		coord_t c;
		c = v[CW-1:0];
		return c;
	endfunction

	// effective clip edge: 0 left, 1 top, 2 right, 3 bottom
	function automatic int clip_side(int k);
		int a;
		int b;
		a = coord_of(area_model[16*k +: 16]);
		b = coord_of(bound_model[16*k +: 16]);
		if (k < 2)
			return (a > b) ? a : b;
		return (a < b) ? a : b;
	endfunction

	function automatic out_t blend_pixel(in_t p);
		int x;
		int y;
		int a;
		int w;
		out_t r;
		x = coord_of(p.pixel_x);
		y = coord_of(p.pixel_y);
		r.written = x >= clip_side(0) && x <= clip_side(2) && y >= clip_side(1) && y <= clip_side(3);
		r.pixel_out = p.background[23:0];
		if (r.written) begin
			a = fill_model[31:24];
			w = 255 - a;
			for (int c = 0; c < 3; c++)
				r.pixel_out[8*c +: 8] = fill_model[8*c +: 8] * w / 255
					+ p.background[8*c +: 8] * a / 255;
		end
		return r;
	endfunction

	function automatic logic [63:0] random_rect();
		int l;
		int t;
		int r;
		int b;
		case ($urandom_range(0, 4))
			0: return RECT_FULL;
			1: begin
				l = 0;
				t = 0;
				r = $urandom_range(1, 2047);
				b = $urandom_range(1, 2047);
			end
			2: begin
				l = int'($urandom_range(0, 65535)) - 32768;
				t = int'($urandom_range(0, 65535)) - 32768;
				r = l + int'($urandom_range(0, 40));
				b = t + int'($urandom_range(0, 40));
			end
			3: return {$urandom, $urandom};
			default: begin
				// single pixel or inverted by one
				l = int'($urandom_range(0, 65535)) - 32768;
				t = int'($urandom_range(0, 65535)) - 32768;
				r = l - int'($urandom_range(0, 1));
				b = t - int'($urandom_range(0, 1));
			end
		endcase
		return {b[15:0], r[15:0], t[15:0], l[15:0]};
	endfunction

	// half of the picks land around the clip edges so both sides of each comparison get hit
	function automatic logic [15:0] pick_coord(int lo, int hi);
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'(lo + int'($urandom_range(0, 4)) - 2);
			2: return 16'(hi + int'($urandom_range(0, 4)) - 2);
			default: begin
				if (lo <= hi)
					return 16'(lo + int'($urandom_range(0, hi - lo)));
				return 16'($urandom);
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_pixel(input in_t p);
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_pixels.size() != 0);
	endtask

	// one write cycle, then cfg_we is dropped before the next write so back-to-back writes never collide
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FILL_COLOR: fill_model = data[31:0];
			REG_AREA_RECT: area_model = data;
			REG_BOUND_RECT: bound_model = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= int'($urandom_range(0, 99)) >= recv_stall_pct;

	always @(posedge clk) begin
		typed_t hint;
		out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = blend_pixel(in_data);
				if (typed_want.size() != 0) begin
					hint = typed_want.pop_front();
					if (hint.known)
						want = hint.want;
				end
				pending_pixels.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: transaction with nothing expected, got %h", $time, out_data);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					if (out_data.pixel_out !== want.pixel_out) begin
						$display("%0t: pixel_out expected %h got %h", $time,
							want.pixel_out, out_data.pixel_out);
						mismatches++;
					end
					if (out_data.written !== want.written) begin
						$display("%0t: written expected %b got %b", $time,
							want.written, out_data.written);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		in_t pix;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_drain();
				write_reg(directed_rows[i].idx, directed_rows[i].wdata);
			end else begin
				typed_want.push_back({directed_rows[i].known, directed_rows[i].want});
				send_pixel(directed_rows[i].pix);
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 63; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 63; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				wait_drain();
				case (blk)
					0: write_reg(REG_FILL_COLOR, {8'h00, 24'($urandom)});
					1: write_reg(REG_FILL_COLOR, {8'hFF, 24'($urandom)});
					default: write_reg(REG_FILL_COLOR, {$urandom, $urandom});
				endcase
				write_reg(REG_AREA_RECT, random_rect());
				write_reg(REG_BOUND_RECT, random_rect());
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_SPARE, {$urandom, $urandom});
				for (int n = 0; n < 119; n++) begin
					pix.pixel_x = pick_coord(clip_side(0), clip_side(2));
					pix.pixel_y = pick_coord(clip_side(1), clip_side(3));
					pix.background = $urandom;
					send_pixel(pix);
				end
			end
		end

		wait_drain();
		repeat (4 * PIPE_DEPTH) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/abcrf_pkg.sv
rtl/abcrf_cfg.sv
rtl/abcrf_clip.sv
rtl/abcrf_mix.sv
rtl/alpha_blend_clipped_rect_fill.sv
bench/alpha_blend_clipped_rect_fill_tb.sv
